// ===== hw/rtl/usc_pkg.sv =====
// ----------------------------------------------------------------------------
// usc_pkg
// Constants for the seconds-to-calendar pipeline: reciprocals for division
// by constants, century thresholds and the March-based month start table.
// ----------------------------------------------------------------------------
`default_nettype none

package usc_pkg;

	// days = floor((secs >> 7) / 675), exact over 25 bits
	localparam int unsigned    DAY_SHIFT   = 35;
	localparam logic [25:0]    DAY_RECIP   = 26'd50903317;
	localparam logic [9:0]     DAY_DIV_LO  = 10'd675;

	// day counts from the epoch at which the century index steps
	localparam logic [15:0]    CENT20_DAYS = 16'd11017;
	localparam logic [15:0]    CENT21_DAYS = 16'd47541;
	localparam logic [15:0]    N2_OFS19    = 16'd25508;
	localparam logic [11:0]    YEAR_BASE19 = 12'd1900;
	localparam logic [11:0]    YEAR_BASE20 = 12'd2000;
	localparam logic [11:0]    YEAR_BASE21 = 12'd2100;

	// weekday: epoch falls on a Thursday
	localparam logic [16:0]    WDAY_OFS      = 17'd3;
	localparam int unsigned    WDAY_SHIFT    = 19;
	localparam logic [16:0]    WDAY_RECIP    = 17'd74899;
	localparam logic [16:0]    DAYS_PER_WEEK = 17'd7;

	localparam int unsigned    HOUR_SHIFT    = 29;
	localparam logic [17:0]    HOUR_RECIP    = 18'd149131;
	localparam logic [16:0]    SECS_PER_HOUR = 17'd3600;

	localparam int unsigned    MIN_SHIFT    = 17;
	localparam logic [11:0]    MIN_RECIP    = 12'd2185;
	localparam logic [11:0]    SECS_PER_MIN = 12'd60;

	localparam int unsigned    Y4_SHIFT    = 28;
	localparam logic [17:0]    Y4_RECIP    = 18'd183735;
	localparam logic [17:0]    DAYS_PER_4Y = 18'd1461;

	localparam int unsigned    MONTHS     = 12;
	localparam logic [3:0]     MI_WRAP    = 4'd10;

	typedef logic [8:0] yday_t;

	// first day of each month counted from 1 March
	function automatic yday_t month_start(input logic [3:0] mi);
		yday_t s;
		unique case (mi)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/unix_seconds_to_calendar_unit.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_unit
// Six-stage pipeline turning a 32-bit Unix seconds count into weekday,
// Gregorian date and time of day.
// ----------------------------------------------------------------------------
// done is v_s6: a beat taken on start moves through v_s1 to v_s6 in order.
// Throughput: one beat per cycle; busy is held low, the pipeline never stalls.
// Each stage holds a few constant multiplies or the month table search.
// Reset: arst_n clears the stage valid bits asynchronously; data regs unreset.
`default_nettype none

module unix_seconds_to_calendar_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] unix_seconds,
	output logic             done,
	output logic [2:0]       weekday,
	output logic [4:0]       day_of_month,
	output logic [3:0]       month_number,
	output logic [11:0]      year_number,
	output logic [4:0]       hour_of_day,
	output logic [5:0]       minute_of_hour,
	output logic [5:0]       second_of_minute
);

	logic        acc;
	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1
	logic [50:0] pday_s1;
	logic [24:0] x_s1;
	logic [6:0]  lo_s1;

	// stage 2
	logic [15:0] days_c;
	logic [25:0] dprod_c;
	logic [24:0] rsub_c;
	logic [15:0] days_s2;
	logic [16:0] tod_s2;

	// stage 3
	logic [15:0] n2_c;
	logic [11:0] yb_c;
	logic [16:0] wd3_c;
	logic [15:0] n2_s3;
	logic [11:0] yb_s3;
	logic [16:0] wd3_s3;
	logic [33:0] wprod_s3;
	logic [34:0] hprod_s3;
	logic [16:0] tod_s3;

	// stage 4
	logic [12:0] q7_c;
	logic [16:0] wsub_c;
	logic [4:0]  hour_c;
	logic [16:0] hsub_c;
	logic [35:0] yprod_s4;
	logic [15:0] n2_s4;
	logic [11:0] yb_s4;
	logic [2:0]  wday_s4;
	logic [4:0]  hour_s4;
	logic [11:0] remh_s4;

	// stage 5
	logic [6:0]  yr4_c;
	logic [17:0] y4d_c;
	logic [15:0] n3sub_c;
	logic [8:0]  n3_s5;
	logic [11:0] year_s5;
	logic [23:0] mprod_s5;
	logic [11:0] remh_s5;
	logic [2:0]  wday_s5;
	logic [4:0]  hour_s5;

	// stage 6
	logic [3:0]  mi_c;
	logic        wrap_c;
	logic [8:0]  msub_c;
	logic [5:0]  minute_c;
	logic [11:0] ssub_c;
	logic [2:0]  wday_s6;
	logic [4:0]  mday_s6;
	logic [3:0]  mon_s6;
	logic [11:0] year_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  minute_s6;
	logic [5:0]  second_s6;

	assign busy = 1'b0;
	assign acc  = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stage 2: whole days and seconds into the day
	always_comb begin
		days_c  = pday_s1[usc_pkg::DAY_SHIFT +: 16];
		dprod_c = 26'(days_c) * 26'(usc_pkg::DAY_DIV_LO);
		rsub_c  = x_s1 - dprod_c[24:0];
	end

	// stage 3: century select, weekday and hour products
	always_comb begin
		priority if (days_s2 >= usc_pkg::CENT21_DAYS) begin
			n2_c = days_s2 - usc_pkg::CENT21_DAYS;
			yb_c = usc_pkg::YEAR_BASE21;
		end else if (days_s2 >= usc_pkg::CENT20_DAYS) begin
			n2_c = days_s2 - usc_pkg::CENT20_DAYS;
			yb_c = usc_pkg::YEAR_BASE20;
		end else begin
			n2_c = days_s2 + usc_pkg::N2_OFS19;
			yb_c = usc_pkg::YEAR_BASE19;
		end
		wd3_c = 17'(days_s2) + usc_pkg::WDAY_OFS;
	end

	// stage 4: weekday and hour remainders
	always_comb begin
		q7_c   = wprod_s3[usc_pkg::WDAY_SHIFT +: 13];
		wsub_c = wd3_s3 - 17'(q7_c) * usc_pkg::DAYS_PER_WEEK;
		hour_c = hprod_s3[usc_pkg::HOUR_SHIFT +: 5];
		hsub_c = tod_s3 - 17'(hour_c) * usc_pkg::SECS_PER_HOUR;
	end

	// stage 5: 4-year cycle and day within the March-based year
	always_comb begin
		yr4_c   = yprod_s4[usc_pkg::Y4_SHIFT +: 7];
		y4d_c   = 18'(yr4_c) * usc_pkg::DAYS_PER_4Y;
		n3sub_c = n2_s4 - y4d_c[17:2];
	end

	// stage 6: month search, day of month, minute and second
	always_comb begin
		mi_c = '0;
		for (int k = 1; k < usc_pkg::MONTHS; k++) begin
			if (n3_s5 >= usc_pkg::month_start(4'(k)))
				mi_c = 4'(k);
		end
		wrap_c   = (mi_c >= usc_pkg::MI_WRAP);
		msub_c   = n3_s5 - usc_pkg::month_start(mi_c) + 9'd1;
		minute_c = mprod_s5[usc_pkg::MIN_SHIFT +: 6];
		ssub_c   = remh_s5 - 12'(minute_c) * usc_pkg::SECS_PER_MIN;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pday_s1 <= 51'(unix_seconds[31:7]) * 51'(usc_pkg::DAY_RECIP);
			x_s1    <= unix_seconds[31:7];
			lo_s1   <= unix_seconds[6:0];
		end
		if (v_s1) begin
			days_s2 <= days_c;
			tod_s2  <= {rsub_c[9:0], lo_s1};
		end
		if (v_s2) begin
			n2_s3    <= n2_c;
			yb_s3    <= yb_c;
			wd3_s3   <= wd3_c;
			wprod_s3 <= 34'(wd3_c) * 34'(usc_pkg::WDAY_RECIP);
			hprod_s3 <= 35'(tod_s2) * 35'(usc_pkg::HOUR_RECIP);
			tod_s3   <= tod_s2;
		end
		if (v_s3) begin
			yprod_s4 <= 36'({n2_s3, 2'b11}) * 36'(usc_pkg::Y4_RECIP);
			n2_s4    <= n2_s3;
			yb_s4    <= yb_s3;
			wday_s4  <= wsub_c[2:0];
			hour_s4  <= hour_c;
			remh_s4  <= hsub_c[11:0];
		end
		if (v_s4) begin
			n3_s5    <= n3sub_c[8:0];
			year_s5  <= yb_s4 + 12'(yr4_c);
			mprod_s5 <= 24'(remh_s4) * 24'(usc_pkg::MIN_RECIP);
			remh_s5  <= remh_s4;
			wday_s5  <= wday_s4;
			hour_s5  <= hour_s4;
		end
		if (v_s5) begin
			wday_s6   <= wday_s5;
			mday_s6   <= msub_c[4:0];
			mon_s6    <= wrap_c ? (mi_c - 4'd9) : (mi_c + 4'd3);
			year_s6   <= year_s5 + 12'(wrap_c);
			hour_s6   <= hour_s5;
			minute_s6 <= minute_c;
			second_s6 <= ssub_c[5:0];
		end
	end

	assign done             = v_s6;
	assign weekday          = wday_s6;
	assign day_of_month     = mday_s6;
	assign month_number     = mon_s6;
	assign year_number      = year_s6;
	assign hour_of_day      = hour_s6;
	assign minute_of_hour   = minute_s6;
	assign second_of_minute = second_s6;

endmodule

`default_nettype wire

// ===== hw/rtl/usc_checker.sv =====
// ----------------------------------------------------------------------------
// usc_checker
// Port-level checks for the seconds-to-calendar unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module usc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [2:0]  weekday,
	input wire logic [4:0]  day_of_month,
	input wire logic [3:0]  month_number,
	input wire logic [11:0] year_number,
	input wire logic [4:0]  hour_of_day,
	input wire logic [5:0]  minute_of_hour,
	input wire logic [5:0]  second_of_minute
);

	// every beat taken gives a matching result on done
	a_beat_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("beat taken without a result six cycles later");

	// no result without a matching earlier beat taken
	a_result_has_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result with no matching beat");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (weekday <= 3'd6) && (hour_of_day <= 5'd23)
			&& (minute_of_hour <= 6'd59) && (second_of_minute <= 6'd59))
		else $error("weekday or time of day out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (day_of_month != 5'd0) && (month_number != 4'd0)
			&& (month_number <= 4'd12) && (year_number >= 12'd1970)
			&& (year_number <= 12'd2106)
			&& ((month_number != 4'd2) || (day_of_month <= 5'd29)))
		else $error("date out of range");

endmodule

bind unix_seconds_to_calendar_unit usc_checker u_usc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.weekday          (weekday),
	.day_of_month     (day_of_month),
	.month_number     (month_number),
	.year_number      (year_number),
	.hour_of_day      (hour_of_day),
	.minute_of_hour   (minute_of_hour),
	.second_of_minute (second_of_minute)
);

`default_nettype wire

// ===== dv/unix_seconds_to_calendar_unit_tb.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_unit_tb
// Drives 32-bit seconds counts into the calendar pipeline and checks every
// returned weekday, date and time-of-day beat against a behavioural model,
// in order, across phases with no gaps, sparse and light sender gaps.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned HALF_DAY     = 43200;
	localparam longint unsigned FULL_DAY     = 86400;
	localparam longint unsigned JDN_EPOCH_M1 = 2440587;
	localparam longint unsigned JDN_SHIFT    = 32044;
	localparam longint unsigned DAYS_400Y    = 146097;
	localparam longint unsigned DAYS_4Y      = 1461;
	localparam longint unsigned MONTH_SPAN   = 153;
	localparam longint unsigned YEAR_OFFSET  = 4800;
	localparam longint unsigned LAST_DAY     = 49710;
	localparam int              DRAIN_LIMIT  = 200;
	localparam int              TAIL_CYCLES  = 12;

	typedef struct packed {
		logic [2:0]  wday;
		logic [4:0]  mday;
		logic [3:0]  mon;
		logic [11:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  sec;
	} civil_t;

	typedef struct {
		logic [31:0] secs;
		civil_t      date;
	} pending_date_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] unix_seconds = '0;
	logic        busy;
	logic        done;
	logic [2:0]  weekday;
	logic [4:0]  day_of_month;
	logic [3:0]  month_number;
	logic [11:0] year_number;
	logic [4:0]  hour_of_day;
	logic [5:0]  minute_of_hour;
	logic [5:0]  second_of_minute;

	logic [31:0]   seconds_q[$];
	pending_date_t dates_due[$];
	logic          took = 1'b0;
	int            gap_pct = 0;
	int            err_count = 0;

	unix_seconds_to_calendar_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.unix_seconds     (unix_seconds),
		.done             (done),
		.weekday          (weekday),
		.day_of_month     (day_of_month),
		.month_number     (month_number),
		.year_number      (year_number),
		.hour_of_day      (hour_of_day),
		.minute_of_hour   (minute_of_hour),
		.second_of_minute (second_of_minute)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic civil_t civil_from_seconds(input logic [31:0] secs);
		longint unsigned s, jdn, n, cent, yr4, mi, tod;
		civil_t r;
		s   = secs;
		jdn = (((s + HALF_DAY) / HALF_DAY) + 2 * JDN_EPOCH_M1 + 1) >> 1;
		n    = jdn + JDN_SHIFT;
		cent = (4 * n + 3) / DAYS_400Y;
		n    = n - (DAYS_400Y * cent) / 4;
		yr4  = (4 * n + 3) / DAYS_4Y;
		n    = n - (DAYS_4Y * yr4) / 4;
		mi   = (5 * n + 2) / MONTH_SPAN;
		tod  = s % FULL_DAY;
		r.wday   = 3'(jdn % 7);
		r.mday   = 5'(n - (MONTH_SPAN * mi + 2) / 5 + 1);
		r.mon    = 4'(mi + 3 - 12 * (mi / 10));
		r.year   = 12'(100 * cent + yr4 + mi / 10 - YEAR_OFFSET);
		r.hour   = 5'(tod / 3600);
		r.minute = 6'((tod % 3600) / 60);
		r.sec    = 6'(tod % 60);
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] secs,
			input logic [11:0] got, input logic [11:0] want);
		if (got !== want)
			flag_mismatch($sformatf("secs=%0d %s got %0d want %0d", secs, name, got, want));
	endtask

	// seconds at a random day boundary, nudged by a small, half-day or one-short-of-a-day offset
	function automatic logic [31:0] near_boundary();
		longint unsigned v;
		longint unsigned offs;
		case ($urandom_range(5))
			0: offs = 0;
			1: offs = 1;
			2: offs = FULL_DAY - 1;
			3: offs = HALF_DAY - 1;
			4: offs = HALF_DAY;
			default: offs = $urandom_range(59);
		endcase
		v = longint'($urandom_range(LAST_DAY)) * FULL_DAY + offs;
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [31:0] random_seconds();
		case ($urandom_range(9))
			0, 1, 2: return near_boundary();
			3:       return 32'hFFFF_FFFF - $urandom_range(200000);
			4:       return $urandom_range(200000);
			default: return $urandom;
		endcase
	endfunction

	// driver: new beat offered at the falling edge once the last one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took) begin
			if (seconds_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
				start        <= 1'b1;
				unix_seconds <= seconds_q.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: results checked before the beat of this edge is logged
	always @(posedge clk) begin
		pending_date_t want;
		took <= arst_n && start && !busy;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (dates_due.size() == 0) begin
					flag_mismatch("result beat with nothing outstanding");
				end else begin
					want = dates_due.pop_front();
					check_field("weekday", want.secs, 12'(weekday), 12'(want.date.wday));
					check_field("day_of_month", want.secs, 12'(day_of_month),
						12'(want.date.mday));
					check_field("month_number", want.secs, 12'(month_number),
						12'(want.date.mon));
					check_field("year_number", want.secs, year_number, want.date.year);
					check_field("hour_of_day", want.secs, 12'(hour_of_day),
						12'(want.date.hour));
					check_field("minute_of_hour", want.secs, 12'(minute_of_hour),
						12'(want.date.minute));
					check_field("second_of_minute", want.secs, 12'(second_of_minute),
						12'(want.date.sec));
				end
			end else if (done !== 1'b0) begin
				flag_mismatch("done is unknown");
			end
			if (start && busy === 1'b0) begin
				want.secs = unix_seconds;
				want.date = civil_from_seconds(unix_seconds);
				dates_due.push_back(want);
			end
		end
	end

	task automatic wait_drained();
		while (seconds_q.size() != 0 || start || dates_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_random(input int count);
		repeat (count) seconds_q.push_back(random_seconds());
	endtask

	initial begin
		int spins;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// epoch, half-day and day edges, top of range, 2038, leap days,
		// century years with and without 29 February
		seconds_q = '{32'd0, 32'd1, 32'd43199, 32'd43200, 32'd86399, 32'd86400,
			32'd31535999, 32'd68169600, 32'd946684799, 32'd946684800,
			32'd951782400, 32'd951868800, 32'h7FFF_FFFF, 32'h8000_0000,
			32'd4102444800, 32'd4107456000, 32'd4107542400,
			32'hFFFF_FFFF - 32'd43200, 32'hFFFF_FFFF - 32'd43199, 32'hFFFF_FFFF,
			32'hAAAA_AAAA, 32'h5555_5555};
		wait_drained();

		gap_pct = 0;
		queue_random(250);
		wait_drained();
		queue_random(250);
		wait_drained();

		gap_pct = 70;
		queue_random(500);
		wait_drained();

		gap_pct = 16;
		queue_random(500);
		wait_drained();

		gap_pct = 0;
		queue_random(500);
		spins = 0;
		while ((seconds_q.size() != 0 || start) && spins < 100000) begin
			@(posedge clk);
			spins++;
		end
		spins = 0;
		while (dates_due.size() != 0 && spins < DRAIN_LIMIT) begin
			@(posedge clk);
			spins++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (dates_due.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", dates_due.size()));

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout waiting for the run to finish");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
